@@ hw/rtl/mandelbrot_escape_time_macros.svh @@
// Assertion macros used by the checker file of the escape-time block.
`ifndef MANDELBROT_ESCAPE_TIME_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_MACROS_SVH

// Same-cycle implication, clocked on clk_i, disabled while rst_ni is low.
`define MBET_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mbet: assertion failed");

// Next-cycle implication, clocked on clk_i, disabled while rst_ni is low.
`define MBET_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mbet: assertion failed");

`endif

@@ hw/rtl/mbet_pkg.sv @@
// Package of the escape-time block: widths, reset values and a helper function.
`timescale 1ns / 1ps

package mbet_pkg;

  localparam int IN_W              = 32;
  localparam int CNT_W             = 12;
  localparam int FRACTION_BITS_DEF = 28;
  localparam int LIMB_W            = 32;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [CNT_W-1:0] LIMIT_RESET   = 12'd511;
  localparam logic             REG_LIMIT_IDX = 1'b0;

  // Magnitude bits of z: below 4 + |c|, c being any 32-bit input.
  function automatic int mag_width(input int fb);
    int m;
    m = (fb + 2 > IN_W - 1) ? fb + 2 : IN_W - 1;
    return m + 1;
  endfunction

endpackage

@@ hw/rtl/mbet_if.sv @@
// Valid/ready channel interfaces for points in and iteration counts out.
`timescale 1ns / 1ps

interface mbet_point_if;
  logic                              valid;
  logic                              ready;
  logic signed [mbet_pkg::IN_W-1:0] c_real;
  logic signed [mbet_pkg::IN_W-1:0] c_imag;

  modport source (output valid, output c_real, output c_imag, input ready);
  modport sink (input valid, input c_real, input c_imag, output ready);
endinterface

interface mbet_count_if;
  logic                        valid;
  logic                        ready;
  logic [mbet_pkg::CNT_W-1:0] iteration_count;

  modport source (output valid, output iteration_count, input ready);
  modport sink (input valid, input iteration_count, output ready);
endinterface

@@ hw/rtl/mbet_apb_regs.sv @@
// APB register file holding the iteration limit.
`timescale 1ns / 1ps

module mbet_apb_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mbet_pkg::APB_AW-1:0]   paddr,
  input  logic [mbet_pkg::APB_DW-1:0]   pwdata,
  output logic [mbet_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output logic [mbet_pkg::CNT_W-1:0]    limit_o
);

  logic [mbet_pkg::CNT_W-1:0] limit_d, limit_q;
  logic                       hit;

  assign hit    = (paddr[mbet_pkg::APB_AW-1] == mbet_pkg::REG_LIMIT_IDX);
  assign pready = 1'b1;

  always_comb begin
    limit_d = limit_q;
    if (psel && penable && pwrite && hit) begin
      limit_d = pwdata[mbet_pkg::CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= mbet_pkg::LIMIT_RESET;
    end else begin
      limit_q <= limit_d;
    end
  end

  assign prdata  = hit ? mbet_pkg::APB_DW'(limit_q) : '0;
  assign limit_o = limit_q;

endmodule

@@ hw/rtl/mbet_mul.sv @@
// Shared unsigned multiplier, one 32x32 limb product per cycle while en_i is high, into an accumulator.
`timescale 1ns / 1ps

module mbet_mul #(
  parameter int OP_W = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic [OP_W-1:0]      a_i,
  input  logic [OP_W-1:0]      b_i,
  output logic                 done_o,
  output logic [2*((OP_W + mbet_pkg::LIMB_W - 1) / mbet_pkg::LIMB_W)
                 *mbet_pkg::LIMB_W-1:0] product_o
);

  localparam int LW     = mbet_pkg::LIMB_W;
  localparam int N      = (OP_W + LW - 1) / LW;
  localparam int PAD_W  = N * LW;
  localparam int ACC_W  = 2 * PAD_W;
  localparam int CW     = (N > 1) ? $clog2(N) : 1;
  localparam logic [CW-1:0] LAST = CW'(N - 1);

  logic [PAD_W-1:0]  a_pad, b_pad;
  logic [2*LW-1:0]   pp;
  logic [ACC_W-1:0]  acc_d, acc_q;
  logic [CW-1:0]     i_d, i_q, j_d, j_q;
  logic              first;

  assign a_pad = PAD_W'(a_i);
  assign b_pad = PAD_W'(b_i);
  assign pp    = a_pad[i_q*LW +: LW] * b_pad[j_q*LW +: LW];
  assign first = (i_q == '0) && (j_q == '0);

  always_comb begin
    acc_d = (first ? '0 : acc_q)
          + (ACC_W'(pp) << (LW * (int'(i_q) + int'(j_q))));
    i_d   = i_q;
    j_d   = j_q;
    if (en_i) begin
      if (j_q == LAST) begin
        j_d = '0;
        i_d = (i_q == LAST) ? '0 : CW'(i_q + 1'b1);
      end else begin
        j_d = CW'(j_q + 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q <= '0;
      j_q <= '0;
    end else begin
      i_q <= i_d;
      j_q <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_q <= acc_d;
    end
  end

  assign done_o    = en_i && (i_q == LAST) && (j_q == LAST);
  assign product_o = acc_d;

endmodule

@@ hw/rtl/mbet_seq.sv @@
// Iteration sequencer: z registers, escape test, update and result register.
`timescale 1ns / 1ps

module mbet_seq #(
  parameter int FRACTION_BITS = mbet_pkg::FRACTION_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [mbet_pkg::CNT_W-1:0]        limit_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [mbet_pkg::IN_W-1:0]  c_real_i,
  input  logic signed [mbet_pkg::IN_W-1:0]  c_imag_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [mbet_pkg::CNT_W-1:0]        out_count_o,
  output logic                              mul_en_o,
  output logic [mbet_pkg::mag_width(FRACTION_BITS)-1:0] mul_a_o,
  output logic [mbet_pkg::mag_width(FRACTION_BITS)-1:0] mul_b_o,
  input  logic                              mul_done_i,
  input  logic [2*((mbet_pkg::mag_width(FRACTION_BITS) + mbet_pkg::LIMB_W - 1)
                 / mbet_pkg::LIMB_W)*mbet_pkg::LIMB_W-1:0] mul_product_i
);

  localparam int MAG_W = mbet_pkg::mag_width(FRACTION_BITS);
  localparam int Z_W   = MAG_W + 1;
  localparam int SQ_W  = 2 * MAG_W - FRACTION_BITS;
  localparam int IN_W  = mbet_pkg::IN_W;
  localparam int CNT_W = mbet_pkg::CNT_W;
  localparam logic [SQ_W:0] FOUR = (SQ_W + 1)'(4) << FRACTION_BITS;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SQX  = 6'b000010,
    ST_SQY  = 6'b000100,
    ST_XY   = 6'b001000,
    ST_UPD  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_e;

  state_e                  state_d, state_q;
  logic [CNT_W-1:0]        count_d, count_q;
  logic                    out_valid_d, out_valid_q;
  logic [CNT_W-1:0]        out_count_d, out_count_q;
  logic signed [IN_W-1:0]  cr_d, cr_q, ci_d, ci_q;
  logic signed [Z_W-1:0]   x_d, x_q, y_d, y_q;
  logic [SQ_W-1:0]         x2_d, x2_q, y2_d, y2_q;
  logic [Z_W-1:0]          p_d, p_q;
  logic [Z_W-1:0]          ax_full, ay_full;
  logic [MAG_W-1:0]        ax, ay;
  logic [SQ_W:0]           sq_sum;
  logic                    escape;
  logic                    neg;
  logic                    load_out;

  assign ax_full = x_q[Z_W-1] ? Z_W'(-x_q) : Z_W'(x_q);
  assign ay_full = y_q[Z_W-1] ? Z_W'(-y_q) : Z_W'(y_q);
  assign ax      = ax_full[MAG_W-1:0];
  assign ay      = ay_full[MAG_W-1:0];
  assign sq_sum  = {1'b0, x2_q} + {1'b0, y2_q};
  assign escape  = (sq_sum >= FOUR);
  assign neg     = x_q[Z_W-1] ^ y_q[Z_W-1];

  assign mul_en_o = (state_q == ST_SQX) || (state_q == ST_SQY)
                 || ((state_q == ST_XY) && !escape);

  always_comb begin
    mul_a_o = ax;
    mul_b_o = ay;
    if (state_q == ST_SQX) begin
      mul_b_o = ax;
    end else if (state_q == ST_SQY) begin
      mul_a_o = ay;
    end
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    cr_d        = cr_q;
    ci_d        = ci_q;
    x_d         = x_q;
    y_d         = y_q;
    x2_d        = x2_q;
    y2_d        = y2_q;
    p_d         = p_q;
    out_count_d = out_count_q;
    load_out    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cr_d    = c_real_i;
          ci_d    = c_imag_i;
          x_d     = Z_W'(c_real_i);
          y_d     = Z_W'(c_imag_i);
          count_d = '0;
          state_d = (limit_i == '0) ? ST_OUT : ST_SQX;
        end
      end
      ST_SQX: begin
        if (mul_done_i) begin
          x2_d    = mul_product_i[FRACTION_BITS +: SQ_W];
          state_d = ST_SQY;
        end
      end
      ST_SQY: begin
        if (mul_done_i) begin
          y2_d    = mul_product_i[FRACTION_BITS +: SQ_W];
          state_d = ST_XY;
        end
      end
      ST_XY: begin
        if (escape) begin
          state_d = ST_OUT;
        end else if (mul_done_i) begin
          p_d     = Z_W'(mul_product_i[FRACTION_BITS-1 +: MAG_W]);
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        // squares are below 4 here, so the low Z_W bits carry them whole
        x_d     = $signed(x2_q[Z_W-1:0]) - $signed(y2_q[Z_W-1:0]) + Z_W'(cr_q);
        y_d     = (neg ? -$signed(p_q) : $signed(p_q)) + Z_W'(ci_q);
        count_d = count_q + 1'b1;
        state_d = (count_d == limit_i) ? ST_OUT : ST_SQX;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_count_d = count_q;
          load_out    = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cr_q        <= cr_d;
    ci_q        <= ci_d;
    x_q         <= x_d;
    y_q         <= y_d;
    x2_q        <= x2_d;
    y2_q        <= y2_d;
    p_q         <= p_d;
    out_count_q <= out_count_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_count_o = out_count_q;

endmodule

@@ hw/rtl/mandelbrot_escape_time.sv @@
// Each iteration forms x*x, y*y and x*y on the shared 32x32 multiplier, then updates z
// (ST_SQX, ST_SQY, ST_XY, ST_UPD); a point whose squares sum to 4 or more escapes in
// ST_XY without the third product, and its count goes out when the limit or escape stops it.
// Throughput: one point at a time, ready again in the cycle that the count is registered.
// Reset: asynchronous, active low; iteration limit returns to 511, sequencer to idle.
`timescale 1ns / 1ps

module mandelbrot_escape_time #(
  parameter int FRACTION_BITS = mbet_pkg::FRACTION_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mbet_pkg::APB_AW-1:0]  paddr,
  input  logic [mbet_pkg::APB_DW-1:0]  pwdata,
  output logic [mbet_pkg::APB_DW-1:0]  prdata,
  output logic                         pready,
  mbet_point_if.sink                   point_i,
  mbet_count_if.source                 count_o
);

  localparam int MAG_W  = mbet_pkg::mag_width(FRACTION_BITS);
  localparam int N      = (MAG_W + mbet_pkg::LIMB_W - 1) / mbet_pkg::LIMB_W;
  localparam int PROD_W = 2 * N * mbet_pkg::LIMB_W;

  logic [mbet_pkg::CNT_W-1:0] limit;
  logic                       mul_en;
  logic [MAG_W-1:0]           mul_a, mul_b;
  logic                       mul_done;
  logic [PROD_W-1:0]          mul_product;

  mbet_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .limit_o (limit)
  );

  mbet_mul #(
    .OP_W (MAG_W)
  ) u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (mul_en),
    .a_i       (mul_a),
    .b_i       (mul_b),
    .done_o    (mul_done),
    .product_o (mul_product)
  );

  mbet_seq #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .limit_i       (limit),
    .in_valid_i    (point_i.valid),
    .in_ready_o    (point_i.ready),
    .c_real_i      (point_i.c_real),
    .c_imag_i      (point_i.c_imag),
    .out_valid_o   (count_o.valid),
    .out_ready_i   (count_o.ready),
    .out_count_o   (count_o.iteration_count),
    .mul_en_o      (mul_en),
    .mul_a_o       (mul_a),
    .mul_b_o       (mul_b),
    .mul_done_i    (mul_done),
    .mul_product_i (mul_product)
  );

endmodule

@@ hw/rtl/mbet_checker.sv @@
// Port-level checker for the escape-time block, bound to the top level.
`timescale 1ns / 1ps
`include "mandelbrot_escape_time_macros.svh"

module mbet_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [mbet_pkg::CNT_W-1:0]  out_count_i
);

  `MBET_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_count_i))
  `MBET_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_i, !in_ready_i)
  `MBET_ASSERT_IMPL(a_result_after_work, $rose(out_valid_i), !$past(in_ready_i))

endmodule

bind mandelbrot_escape_time mbet_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (point_i.valid),
  .in_ready_i  (point_i.ready),
  .out_valid_i (count_o.valid),
  .out_ready_i (count_o.ready),
  .out_count_i (count_o.iteration_count)
);

@@ tb/mandelbrot_escape_time_tb.sv @@
// Self-checking testbench of the escape-time block: directed and random points against a predictor.
`timescale 1ns / 1ps

module mandelbrot_escape_time_tb;

  localparam int FRACTION_BITS_DEF = mbet_pkg::FRACTION_BITS_DEF;
  localparam int IN_W              = mbet_pkg::IN_W;
  localparam int CNT_W             = mbet_pkg::CNT_W;
  localparam int APB_AW            = mbet_pkg::APB_AW;
  localparam int APB_DW            = mbet_pkg::APB_DW;
  localparam logic             REG_LIMIT_IDX = mbet_pkg::REG_LIMIT_IDX;
  localparam logic [CNT_W-1:0] LIMIT_RESET   = mbet_pkg::LIMIT_RESET;

  localparam int FB          = FRACTION_BITS_DEF;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 146;

  localparam logic [APB_AW-1:0] LIMIT_ADDR = APB_AW'(4 * REG_LIMIT_IDX);
  localparam logic [APB_AW-1:0] SPARE_ADDR = LIMIT_ADDR + APB_AW'(4);

  localparam logic signed [IN_W-1:0] Q_ONE = 32'sh1000_0000;
  localparam logic signed [IN_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [IN_W-1:0] Q_MIN = 32'sh8000_0000;

  typedef struct {
    logic signed [IN_W-1:0] re;
    logic signed [IN_W-1:0] im;
    bit                     drain_first;
  } point_t;

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;

  mbet_point_if point_if ();
  mbet_count_if count_if ();

  mandelbrot_escape_time #(
    .FRACTION_BITS(FB)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .point_i(point_if),
    .count_o(count_if)
  );

  point_t            points_to_send[$];
  logic [CNT_W-1:0]  expected_counts[$];
  logic [CNT_W-1:0]  cur_limit;
  int                errors;
  int                cycles;
  int                send_idle_pct;
  int                recv_stall_pct;
  int                hold_reqs;
  int                hold_seen;
  int                hold_left;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Escape-time count of one point at the given limit, z held in Q.FB
  function automatic logic [CNT_W-1:0] escape_count(input logic signed [IN_W-1:0] cr,
                                                    input logic signed [IN_W-1:0] ci,
                                                    input logic [CNT_W-1:0] lim);
    longint       c_re;
    longint       c_im;
    longint       x;
    longint       y;
    logic [127:0] ax;
    logic [127:0] ay;
    logic [127:0] x2;
    logic [127:0] y2;
    logic [127:0] xy;
    logic [127:0] four;
    bit           neg;
    int           n;
    c_re = cr;
    c_im = ci;
    x    = c_re;
    y    = c_im;
    four = 128'd4 << FB;
    n    = 0;
    while (n < int'(lim)) begin
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      x2 = (ax * ax) >> FB;
      y2 = (ay * ay) >> FB;
      if (x2 + y2 >= four) break;
      xy  = (ax * ay) >> (FB - 1);
      neg = (x < 0) != (y < 0);
      x   = longint'(x2[63:0]) - longint'(y2[63:0]) + c_re;
      y   = (neg ? -longint'(xy[63:0]) : longint'(xy[63:0])) + c_im;
      n++;
    end
    return n[CNT_W-1:0];
  endfunction

  function automatic point_t rand_point();
    point_t p;
    int     sel;
    sel = $urandom_range(99);
    p.drain_first = 1'b0;
    if (sel < 60) begin
      // box around the set
      p.re = 32'($urandom_range(12 << 26)) - 32'(9 << 26);
      p.im = 32'($urandom_range(12 << 26)) - 32'(6 << 26);
    end else if (sel < 75) begin
      // close to the real axis
      p.re = 32'($urandom_range(9 << 26)) - 32'(8 << 26);
      p.im = 32'($urandom_range(1 << 21)) - 32'(1 << 20);
    end else begin
      p.re = $urandom();
      p.im = $urandom();
    end
    return p;
  endfunction

  task automatic report_mismatch(input string what, input logic [CNT_W-1:0] got,
                                 input logic [CNT_W-1:0] want);
    $display("ERROR at cycle %0d: %s: iteration_count got %0d want %0d",
             cycles, what, got, want);
    errors++;
  endtask

  task automatic queue_point(input logic signed [IN_W-1:0] re,
                             input logic signed [IN_W-1:0] im);
    point_t p;
    p.re          = re;
    p.im          = im;
    p.drain_first = 1'b0;
    points_to_send.push_back(p);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    while (points_to_send.size() != 0 || expected_counts.size() != 0 || point_if.valid)
      @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == LIMIT_ADDR) cur_limit = data[CNT_W-1:0];
  endtask

  // point driver
  always @(posedge clk_i) begin
    point_t p;
    bit     go;
    if (!rst_ni) begin
      point_if.valid <= 1'b0;
    end else begin
      if (point_if.valid && point_if.ready)
        expected_counts.push_back(escape_count(point_if.c_real, point_if.c_imag, cur_limit));
      if (!point_if.valid || point_if.ready) begin
        go = 1'b0;
        if (points_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
          go = !(points_to_send[0].drain_first && expected_counts.size() != 0);
        if (go) begin
          p = points_to_send.pop_front();
          point_if.c_real <= p.re;
          point_if.c_imag <= p.im;
          point_if.valid  <= 1'b1;
        end else begin
          point_if.valid <= 1'b0;
        end
      end
    end
  end

  // count receiver ready, with the long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      count_if.ready <= 1'b0;
    end else if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
      count_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      count_if.ready <= 1'b0;
    end else begin
      count_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // count monitor
  always @(posedge clk_i) begin
    logic [CNT_W-1:0] want;
    if (rst_ni && count_if.valid && count_if.ready) begin
      if (expected_counts.size() == 0) begin
        report_mismatch("count with no point outstanding", count_if.iteration_count, '0);
      end else begin
        want = expected_counts.pop_front();
        if (count_if.iteration_count !== want)
          report_mismatch("wrong count", count_if.iteration_count, want);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("mandelbrot_escape_time test failed");
      $finish;
    end
  end

  initial begin : stimulus
    point_t           p;
    logic [CNT_W-1:0] lim;
    logic [APB_DW-1:0] data;
    int               phase_limits[RAND_PHASES];
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    point_if.valid  = 1'b0;
    point_if.c_real = '0;
    point_if.c_imag = '0;
    count_if.ready  = 1'b0;
    cur_limit       = LIMIT_RESET;
    errors          = 0;
    cycles          = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_reqs       = 0;
    hold_seen       = 0;
    hold_left       = 0;
    phase_limits    = '{30, 511, 7, 100, 255, 2, 60, 0};
    phase_limits[RAND_PHASES-1] = $urandom_range(150, 1);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed points at the reset limit
    queue_point('0, '0);
    queue_point(Q_MAX, Q_MAX);
    queue_point(Q_MIN, Q_MIN);
    queue_point(Q_MIN, Q_MAX);
    queue_point(Q_MAX, Q_MIN);
    queue_point(-2 * Q_ONE, '0);
    queue_point(-2 * Q_ONE + 1, '0);
    queue_point('0, 2 * Q_ONE);
    queue_point(-Q_ONE, '0);
    queue_point(Q_ONE / 4, '0);
    queue_point('0, Q_ONE);
    queue_point(Q_ONE, '0);
    queue_point(-(Q_ONE / 4) * 3, Q_ONE / 10);
    queue_point(-1, -1);
    queue_point(1, 1);
    queue_point(-(Q_ONE / 4) * 7, '0);
    wait_idle();

    // write to an unmapped register leaves the limit alone
    cfg_write(SPARE_ADDR, 32'd5);
    queue_point('0, '0);
    wait_idle();

    // limit zero: no iteration at all
    cfg_write(LIMIT_ADDR, 32'd0);
    queue_point('0, '0);
    queue_point(-Q_ONE, '0);
    wait_idle();

    cfg_write(LIMIT_ADDR, 32'd1);
    queue_point('0, '0);
    queue_point(Q_MAX, Q_MAX);
    queue_point(Q_ONE, '0);
    wait_idle();

    // top limit, upper data bits set
    cfg_write(LIMIT_ADDR, 32'hFFFF_FFFF);
    queue_point('0, '0);
    queue_point(-Q_ONE, '0);
    queue_point(-(Q_ONE / 8), (Q_ONE / 4) * 3);
    wait_idle();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      lim  = CNT_W'(phase_limits[ph]);
      data = $urandom();
      data[CNT_W-1:0] = lim;
      cfg_write(LIMIT_ADDR, data);
      @(negedge clk_i);
      case (ph % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 56;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 56;
        end
        default: begin
          send_idle_pct  = 26;
          recv_stall_pct = 26;
        end
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        p = rand_point();
        p.drain_first = (k == 40);
        points_to_send.push_back(p);
      end
      if (ph % 4 == 0) hold_reqs++;
      wait_idle();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (64) @(posedge clk_i);
    if (errors == 0) begin
      $display("mandelbrot_escape_time test passed");
    end else begin
      $display("mandelbrot_escape_time test failed");
    end
    $finish;
  end

endmodule
